[rtl/core/csrmv_pkg.sv]
// ----------------------------------------------------------------------------
// csrmv_pkg
// shared types and constants for the csr sparse matrix multi-vector block
// ----------------------------------------------------------------------------
package csrmv_pkg;

    // field widths
    localparam int FUNC_W   = 2;
    localparam int VEC_W    = 2;
    localparam int COLUMN_W = 12;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 64;
    localparam int RND_W    = 48;
    localparam int ROW_W    = 16;

    // columns that the column field can reach
    localparam int COLUMN_SPAN = 1 << COLUMN_W;

    // parameter defaults
    localparam int DEF_NUM_VECTORS = 4;
    localparam int DEF_MAX_COLUMNS = 4096;

    // command queue between front and back
    localparam int QPTR_W      = 2;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MAC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd2;

    // rounding bias for q32.32 to q32.16
    localparam logic signed [SUM_W-1:0] ROUND_BIAS = 64'sd32768;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // classified command held in the queue
    typedef struct packed {
        logic                is_load;
        logic                is_mac;
        logic                close;
        logic [VEC_W-1:0]    vec;
        logic [COLUMN_W-1:0] column;
        logic                col_ok;
        logic [VALUE_W-1:0]  value;
    } t_cmd;

    // control carried down the back pipeline
    typedef struct packed {
        logic valid;
        logic mac;
        logic close;
    } t_stage;

endpackage

[rtl/core/csrmv_front.sv]
// ----------------------------------------------------------------------------
// csrmv_front
// accepts input transactions, classifies them and queues the useful ones
// ----------------------------------------------------------------------------
module csrmv_front import csrmv_pkg::*; #(
    parameter int NUM_VECTORS = DEF_NUM_VECTORS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [VEC_W-1:0]    i_vec_index,
    input  logic [COLUMN_W-1:0] i_column,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic                i_last_in_row,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  logic                i_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic col_ok, vec_ok, keep, push, full;
    t_cmd cmd_in;

    assign col_ok = 32'(i_column) < 32'(MAX_COLUMNS);
    assign vec_ok = 32'(i_vec_index) < 32'(NUM_VECTORS);

    always_comb begin
        cmd_in.is_load = (i_func == FUNC_LOAD);
        cmd_in.is_mac  = (i_func == FUNC_MAC);
        cmd_in.close   = (i_func == FUNC_CLOSE) || ((i_func == FUNC_MAC) && i_last_in_row);
        cmd_in.vec     = i_vec_index;
        cmd_in.column  = i_column;
        cmd_in.col_ok  = col_ok;
        cmd_in.value   = i_value;
    end

    // loads outside the store or past the vectors, and the unused code, are dropped here
    assign keep = (cmd_in.is_load && col_ok && vec_ok) || cmd_in.is_mac || cmd_in.close;
    assign full = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign push = i_in_valid && !full && keep;

    assign o_in_stall  = full;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

[rtl/core/csrmv_lane.sv]
// ----------------------------------------------------------------------------
// csrmv_lane
// one dense vector: element store, multiply, round and saturating accumulate
// ----------------------------------------------------------------------------
module csrmv_lane import csrmv_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_wr,
    input  logic [COLUMN_W-1:0] i_column,
    input  logic [VALUE_W-1:0]  i_wdata,
    input  logic [VALUE_W-1:0]  i_s1_value,
    input  logic                i_s1_col_ok,
    input  t_stage              i_s3,
    output logic [SUM_W-1:0]    o_sum,
    output logic                o_sat
);

    localparam int StoreDepth = (MAX_COLUMNS > COLUMN_SPAN) ? COLUMN_SPAN : MAX_COLUMNS;
    localparam int AddrW      = $clog2(StoreDepth);

    logic [VALUE_W-1:0] r_mem [StoreDepth];
    logic [VALUE_W-1:0] r_rd;
    logic [SUM_W-1:0]   r_prod;
    logic [RND_W-1:0]   r_rnd;
    logic [SUM_W-1:0]   r_acc;
    logic               r_sat;

    logic [AddrW-1:0]          addr;
    logic signed [VALUE_W-1:0] op_a, op_b;
    logic signed [SUM_W-1:0]   prod, biased;
    logic [SUM_W-1:0]          rnd_ext, sum, acc_nxt;
    logic                      ovf, sat_nxt;

    assign addr = i_column[AddrW-1:0];

    // store port: write on loads, read every advancing cycle
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[addr] <= i_wdata;
        end
        if (i_adv) begin
            r_rd <= r_mem[addr];
        end
    end

    // columns past the store use a zero element
    assign op_a   = i_s1_value;
    assign op_b   = i_s1_col_ok ? r_rd : '0;
    assign prod   = op_a * op_b;
    assign biased = $signed(r_prod) + ROUND_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= prod;
            r_rnd  <= biased[SUM_W-1:SUM_W-RND_W];
        end
    end

    assign rnd_ext = {{(SUM_W-RND_W){r_rnd[RND_W-1]}}, r_rnd};
    assign sum     = r_acc + rnd_ext;
    assign ovf     = (r_acc[SUM_W-1] == rnd_ext[SUM_W-1]) && (sum[SUM_W-1] != r_acc[SUM_W-1]);

    always_comb begin
        acc_nxt = r_acc;
        sat_nxt = r_sat;
        if (i_s3.mac) begin
            if (ovf) begin
                acc_nxt = r_acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
                sat_nxt = 1'b1;
            end else begin
                acc_nxt = sum;
            end
        end
    end

    assign o_sum = acc_nxt;
    assign o_sat = sat_nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_adv && i_s3.valid) begin
            if (i_s3.close) begin
                r_acc <= '0;
                r_sat <= 1'b0;
            end else begin
                r_acc <= acc_nxt;
                r_sat <= sat_nxt;
            end
        end
    end

endmodule

[rtl/core/csrmv_back.sv]
// ----------------------------------------------------------------------------
// csrmv_back
// executes queued commands across all vector lanes in a four-stage pipeline
// ----------------------------------------------------------------------------
module csrmv_back import csrmv_pkg::*; #(
    parameter int NUM_VECTORS = DEF_NUM_VECTORS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  t_cmd                              i_cmd,
    output logic                              o_pop,
    input  logic                              i_drain_ready,
    output logic                              o_load,
    output logic [NUM_VECTORS-1:0][SUM_W-1:0] o_sums,
    output logic [NUM_VECTORS-1:0]            o_sats
);

    t_stage             r_s1, r_s2, r_s3;
    logic [VALUE_W-1:0] r_s1_value;
    logic               r_s1_col_ok;

    logic adv, pop;

    // the whole pipeline holds while a row close waits for the drain
    assign adv    = !(r_s3.valid && r_s3.close && !i_drain_ready);
    assign pop    = i_cmd_valid && adv;
    assign o_pop  = pop;
    assign o_load = r_s3.valid && r_s3.close && i_drain_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
            r_s3 <= '0;
        end else if (adv) begin
            r_s1.valid <= pop;
            r_s1.mac   <= pop && i_cmd.is_mac;
            r_s1.close <= pop && i_cmd.close;
            r_s2       <= r_s1;
            r_s3       <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_value  <= i_cmd.value;
            r_s1_col_ok <= i_cmd.col_ok;
        end
    end

    for (genvar g = 0; g < NUM_VECTORS; g++) begin : g_lane
        logic wr;
        assign wr = pop && i_cmd.is_load && (32'(i_cmd.vec) == 32'(g));

        csrmv_lane #(
            .MAX_COLUMNS(MAX_COLUMNS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (adv),
            .i_wr        (wr),
            .i_column    (i_cmd.column),
            .i_wdata     (i_cmd.value),
            .i_s1_value  (r_s1_value),
            .i_s1_col_ok (r_s1_col_ok),
            .i_s3        (r_s3),
            .o_sum       (o_sums[g]),
            .o_sat       (o_sats[g])
        );
    end

endmodule

[rtl/core/csrmv_drain.sv]
// ----------------------------------------------------------------------------
// csrmv_drain
// holds one closed row and hands out its per-vector sums one at a time
// ----------------------------------------------------------------------------
module csrmv_drain import csrmv_pkg::*; #(
    parameter int NUM_VECTORS = DEF_NUM_VECTORS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [NUM_VECTORS-1:0][SUM_W-1:0] i_sums,
    input  logic [NUM_VECTORS-1:0]            i_sats,
    output logic                              o_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ROW_W-1:0]                  o_row_index,
    output logic [VEC_W-1:0]                  o_out_vector,
    output logic [SUM_W-1:0]                  o_row_sum,
    output logic                              o_saturated,
    output logic                              o_last_of_row
);

    localparam int CntW = $clog2(NUM_VECTORS + 1);

    logic [NUM_VECTORS-1:0][SUM_W-1:0] r_sum;
    logic [NUM_VECTORS-1:0]            r_sat;
    logic [CntW-1:0]                   r_cnt;
    logic [VEC_W-1:0]                  r_vec;
    logic [ROW_W-1:0]                  r_row;

    logic take, last;

    assign last    = (r_cnt == CntW'(1));
    assign take    = (r_cnt != '0) && !i_out_stall;
    assign o_ready = (r_cnt == '0) || (last && !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_vec <= '0;
            r_row <= '0;
        end else begin
            if (i_load) begin
                r_cnt <= CntW'(NUM_VECTORS);
                r_vec <= '0;
            end else if (take) begin
                r_cnt <= r_cnt - 1'b1;
                r_vec <= r_vec + 1'b1;
            end
            if (take && last) begin
                r_row <= r_row + 1'b1;
            end
        end
    end

    // sums shift toward slot zero as they are taken
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= i_sums;
            r_sat <= i_sats;
        end else if (take) begin
            for (int k = 0; k < NUM_VECTORS - 1; k++) begin
                r_sum[k] <= r_sum[k+1];
                r_sat[k] <= r_sat[k+1];
            end
        end
    end

    assign o_out_valid   = (r_cnt != '0);
    assign o_row_index   = r_row;
    assign o_out_vector  = r_vec;
    assign o_row_sum     = r_sum[0];
    assign o_saturated   = r_sat[0];
    assign o_last_of_row = last;

endmodule

[rtl/core/csr_sparse_matrix_multi_vector.sv]
// ----------------------------------------------------------------------------
// csr_sparse_matrix_multi_vector
// output: a closing transaction's sums pass through the queue, s1, s2, s3 and
//   the drain; the row holds the output until its NUM_VECTORS sums are taken
// throughput: one input transaction per cycle while the queue has room and no
//   close is held, set by the per-lane multiply-accumulate pipeline
// reset: synchronous; clears queue, pipeline, accumulators, marks and row count
// ----------------------------------------------------------------------------
module csr_sparse_matrix_multi_vector import csrmv_pkg::*; #(
    parameter int NUM_VECTORS = DEF_NUM_VECTORS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [FUNC_W-1:0]          i_func,
    input  logic [VEC_W-1:0]           i_vec_index,
    input  logic [COLUMN_W-1:0]        i_column,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_last_in_row,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ROW_W-1:0]           o_row_index,
    output logic [VEC_W-1:0]           o_out_vector,
    output logic signed [SUM_W-1:0]    o_row_sum,
    output logic                       o_saturated,
    output logic                       o_last_of_row
);

    // front to back: classified commands through a short queue
    logic cmd_valid;
    t_cmd cmd;
    logic pop;

    // back to drain: one closed row, all vectors at once
    logic                              drain_ready;
    logic                              drain_load;
    logic [NUM_VECTORS-1:0][SUM_W-1:0] row_sums;
    logic [NUM_VECTORS-1:0]            row_sats;
    logic [SUM_W-1:0]                  out_sum;

    // the front takes every transaction the queue has room for; loads that
    // fall outside the store or past the vectors, and the unused function code, die here
    csrmv_front #(
        .NUM_VECTORS(NUM_VECTORS),
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_vec_index   (i_vec_index),
        .i_column      (i_column),
        .i_value       (i_value),
        .i_last_in_row (i_last_in_row),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_pop         (pop)
    );

    // the back pops one command per cycle unless held for the drain: store
    // access, multiply, round, saturating add; loads and reads hit the stores
    // in arrival order, so a nonzero always sees every element loaded ahead of it
    csrmv_back #(
        .NUM_VECTORS(NUM_VECTORS),
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_pop         (pop),
        .i_drain_ready (drain_ready),
        .o_load        (drain_load),
        .o_sums        (row_sums),
        .o_sats        (row_sats)
    );

    // the drain is the output register; it takes the next row on the very
    // cycle its last sum leaves, so rows go out back to back
    csrmv_drain #(
        .NUM_VECTORS(NUM_VECTORS)
    ) u_drain (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (drain_load),
        .i_sums        (row_sums),
        .i_sats        (row_sats),
        .o_ready       (drain_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_row_index   (o_row_index),
        .o_out_vector  (o_out_vector),
        .o_row_sum     (out_sum),
        .o_saturated   (o_saturated),
        .o_last_of_row (o_last_of_row)
    );

    assign o_row_sum = out_sum;

endmodule

[rtl/core/csrmv_checker.sv]
// ----------------------------------------------------------------------------
// csrmv_checker
// port-level checks of the result sequence, bound to the top level
// ----------------------------------------------------------------------------
module csrmv_checker import csrmv_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [ROW_W-1:0]        o_row_index,
    input logic [VEC_W-1:0]        o_out_vector,
    input logic signed [SUM_W-1:0] o_row_sum,
    input logic                    o_saturated,
    input logic                    o_last_of_row
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_row_sum)
            && $stable(o_row_index) && $stable(o_out_vector) && $stable(o_saturated)
            && $stable(o_last_of_row))
        else $error("stalled result changed");

    // inside a row the next vector follows at once, same row number
    a_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_of_row |=> o_out_valid
            && (o_out_vector == 2'($past(o_out_vector) + 2'd1))
            && (o_row_index == $past(o_row_index)))
        else $error("row sums not in vector order");

    // a row that follows at once starts with vector zero of the next row
    a_next_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last_of_row |=> !o_out_valid
            || ((o_out_vector == '0) && (o_row_index == 16'($past(o_row_index) + 16'd1))))
        else $error("row number did not advance");

    // reset empties queue and drain
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not empty after reset");

endmodule

bind csr_sparse_matrix_multi_vector csrmv_checker u_checker (.*);
